// ===== sv/ltc_pkg.sv =====
package ltc_pkg;

  localparam int unsigned QuoW    = 32;
  localparam int unsigned SptW    = 6;
  localparam int unsigned HeadsW  = 9;
  localparam int unsigned LeftW   = 23;
  localparam int unsigned CylW    = 10;
  localparam int unsigned HeadW   = 8;
  localparam int unsigned DriveW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  localparam logic [7:0]        ReadFunc    = 8'h02;
  localparam logic [HeadsW-1:0] HeadsMax    = 9'd256;
  localparam logic [SptW-1:0]   SptReset    = 6'd63;
  localparam logic [HeadsW-1:0] HeadsReset  = 9'd16;
  localparam logic [QuoW-1:0]   BaseReset   = 32'd0;
  localparam logic [DriveW-1:0] DriveReset  = 8'd128;

  typedef enum logic [CfgIdxW-1:0] {
    RegSpt   = 2'd0,
    RegHeads = 2'd1,
    RegBase  = 2'd2,
    RegDrive = 2'd3
  } cfg_reg_e;

  // sideband through the track divider
  typedef struct packed {
    logic [QuoW-1:0]  rel;
    logic [LeftW-1:0] left;
  } side1_t;

  // sideband through the head divider
  typedef struct packed {
    logic [QuoW-1:0]  rel;
    logic [LeftW-1:0] left;
    logic [SptW-1:0]  in_track;
  } side2_t;

  typedef struct packed {
    logic [SptW-1:0]  chunk_count;
    logic [CylW-1:0]  cylinder;
    logic [HeadW-1:0] head;
    logic [SptW-1:0]  track_sector;
    logic [15:0]      ax_word;
    logic [15:0]      cx_word;
    logic [15:0]      dx_word;
    logic [QuoW-1:0]  next_rel_sector;
    logic             request_done;
    logic             cylinder_overflow;
  } result_t;

endpackage

// ===== sv/ltc_div_cell.sv =====
module ltc_div_cell #(
  parameter int unsigned DW = ltc_pkg::SptW,
  parameter int unsigned QW = ltc_pkg::QuoW,
  parameter int unsigned SW = $bits(ltc_pkg::side1_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [DW-1:0] divisor_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [SW-1:0] side_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_i, quo_i[QW-1]};
    fits  = (trial >= {1'b0, divisor_i});
    diff  = trial - {1'b0, divisor_i};
    rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
    quo_d = {quo_i[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

// ===== sv/ltc_div_chain.sv =====
module ltc_div_chain #(
  parameter int unsigned DW = ltc_pkg::SptW,
  parameter int unsigned QW = ltc_pkg::QuoW,
  parameter int unsigned SW = $bits(ltc_pkg::side1_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [DW-1:0] divisor_i,
  input  logic          valid_i,
  input  logic [QW-1:0] dividend_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o,
  output logic [SW-1:0] side_o
);

  logic          valid_w [QW+1];
  logic [DW-1:0] rem_w   [QW+1];
  logic [QW-1:0] quo_w   [QW+1];
  logic [SW-1:0] side_w  [QW+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = '0;
  assign quo_w[0]   = dividend_i;
  assign side_w[0]  = side_i;

  // one quotient bit per cell
  for (genvar i = 0; i < QW; i++) begin : g_cell
    ltc_div_cell #(
      .DW(DW),
      .QW(QW),
      .SW(SW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en_i),
      .divisor_i(divisor_i),
      .valid_i  (valid_w[i]),
      .rem_i    (rem_w[i]),
      .quo_i    (quo_w[i]),
      .side_i   (side_w[i]),
      .valid_o  (valid_w[i+1]),
      .rem_o    (rem_w[i+1]),
      .quo_o    (quo_w[i+1]),
      .side_o   (side_w[i+1])
    );
  end

  assign valid_o     = valid_w[QW];
  assign quotient_o  = quo_w[QW];
  assign remainder_o = rem_w[QW];
  assign side_o      = side_w[QW];

endmodule

// ===== sv/ltc_out_buf.sv =====
module ltc_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ltc_pkg::result_t data_i,
  output logic             advance_o,
  output logic             valid_o,
  input  logic             ready_i,
  output ltc_pkg::result_t data_o
);

  logic             out_valid_q;
  ltc_pkg::result_t out_data_q;
  logic             skid_valid_q;
  ltc_pkg::result_t skid_data_q;
  logic             take;
  logic             drain;

  assign advance_o = !skid_valid_q;
  assign take      = valid_i && !skid_valid_q;
  assign drain     = ready_i || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      out_valid_q  <= skid_valid_q || take;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (take) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

// ===== sv/lba_to_chs_track_chunker.sv =====
// Converts a partition-relative sector into cylinder, head and sector for a
// BIOS disk-read request and emits the chunk that reaches to the end of the
// track or of the request, whichever comes first. One transaction per cycle
// is taken while the skid buffer is empty; a result passes the base add
// register, 32 cells each of the sector and head dividers (restoring chains
// that retire one quotient bit per cell) and one output register.
// A one-entry skid buffer keeps input flowing while a result waits.
// Configuration writes take effect on the next cycle and are to be made
// only while no transaction is in flight.
module lba_to_chs_track_chunker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ltc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ltc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ltc_pkg::QuoW-1:0]       rel_sector_i,
  input  logic [ltc_pkg::LeftW-1:0]      sectors_left_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ltc_pkg::SptW-1:0]       chunk_count_o,
  output logic [ltc_pkg::CylW-1:0]       cylinder_o,
  output logic [ltc_pkg::HeadW-1:0]      head_o,
  output logic [ltc_pkg::SptW-1:0]       track_sector_o,
  output logic [15:0]                    ax_word_o,
  output logic [15:0]                    cx_word_o,
  output logic [15:0]                    dx_word_o,
  output logic [ltc_pkg::QuoW-1:0]       next_rel_sector_o,
  output logic                           request_done_o,
  output logic                           cylinder_overflow_o
);

  localparam int unsigned QW  = ltc_pkg::QuoW;
  localparam int unsigned S1W = $bits(ltc_pkg::side1_t);
  localparam int unsigned S2W = $bits(ltc_pkg::side2_t);

  logic [ltc_pkg::SptW-1:0]   spt_q;
  logic [ltc_pkg::HeadsW-1:0] heads_q;
  logic [QW-1:0]              base_q;
  logic [ltc_pkg::DriveW-1:0] drive_q;
  logic [ltc_pkg::SptW-1:0]   spt_eff;
  logic [ltc_pkg::HeadsW-1:0] heads_eff;

  logic                       advance;
  logic                       ent_valid_q;
  logic [QW-1:0]              ent_abs_q;
  ltc_pkg::side1_t            ent_side_q;

  logic                       c1_valid;
  logic [QW-1:0]              c1_track;
  logic [ltc_pkg::SptW-1:0]   c1_in_track;
  logic [S1W-1:0]             c1_side_raw;
  ltc_pkg::side1_t            c1_side;
  ltc_pkg::side2_t            c2_side_in;

  logic                       c2_valid;
  logic [QW-1:0]              c2_cyl;
  logic [ltc_pkg::HeadsW-1:0] c2_head;
  logic [S2W-1:0]             c2_side_raw;
  ltc_pkg::side2_t            c2_side;

  logic [ltc_pkg::SptW-1:0]   chunk_full;
  logic [ltc_pkg::SptW-1:0]   chunk;
  logic [ltc_pkg::SptW-1:0]   sec;
  logic [ltc_pkg::CylW-1:0]   cyl10;
  ltc_pkg::result_t           res;
  ltc_pkg::result_t           out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q   <= ltc_pkg::SptReset;
      heads_q <= ltc_pkg::HeadsReset;
      base_q  <= ltc_pkg::BaseReset;
      drive_q <= ltc_pkg::DriveReset;
    end else if (cfg_we_i) begin
      case (ltc_pkg::cfg_reg_e'(cfg_index_i))
        ltc_pkg::RegSpt:   spt_q   <= cfg_data_i[ltc_pkg::SptW-1:0];
        ltc_pkg::RegHeads: heads_q <= cfg_data_i[ltc_pkg::HeadsW-1:0];
        ltc_pkg::RegBase:  base_q  <= cfg_data_i[QW-1:0];
        ltc_pkg::RegDrive: drive_q <= cfg_data_i[ltc_pkg::DriveW-1:0];
        default: ;
      endcase
    end
  end

  // zero geometry reads as one, more than 256 heads reads as 256
  always_comb begin
    spt_eff = (spt_q == '0) ? ltc_pkg::SptW'(1) : spt_q;
    if (heads_q == '0) begin
      heads_eff = ltc_pkg::HeadsW'(1);
    end else if (heads_q > ltc_pkg::HeadsMax) begin
      heads_eff = ltc_pkg::HeadsMax;
    end else begin
      heads_eff = heads_q;
    end
  end

  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (advance) begin
      ent_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ent_abs_q       <= base_q + rel_sector_i;
      ent_side_q.rel  <= rel_sector_i;
      ent_side_q.left <= sectors_left_i;
    end
  end

  ltc_div_chain #(
    .DW(ltc_pkg::SptW),
    .QW(QW),
    .SW(S1W)
  ) u_track_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .divisor_i  (spt_eff),
    .valid_i    (ent_valid_q),
    .dividend_i (ent_abs_q),
    .side_i     (ent_side_q),
    .valid_o    (c1_valid),
    .quotient_o (c1_track),
    .remainder_o(c1_in_track),
    .side_o     (c1_side_raw)
  );

  always_comb begin
    c1_side             = ltc_pkg::side1_t'(c1_side_raw);
    c2_side_in.rel      = c1_side.rel;
    c2_side_in.left     = c1_side.left;
    c2_side_in.in_track = c1_in_track;
  end

  ltc_div_chain #(
    .DW(ltc_pkg::HeadsW),
    .QW(QW),
    .SW(S2W)
  ) u_head_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .divisor_i  (heads_eff),
    .valid_i    (c1_valid),
    .dividend_i (c1_track),
    .side_i     (c2_side_in),
    .valid_o    (c2_valid),
    .quotient_o (c2_cyl),
    .remainder_o(c2_head),
    .side_o     (c2_side_raw)
  );

  always_comb begin
    c2_side    = ltc_pkg::side2_t'(c2_side_raw);
    chunk_full = spt_eff - c2_side.in_track;
    chunk      = (c2_side.left < {{(ltc_pkg::LeftW-ltc_pkg::SptW){1'b0}}, chunk_full}) ?
                 c2_side.left[ltc_pkg::SptW-1:0] : chunk_full;
    sec        = c2_side.in_track + ltc_pkg::SptW'(1);
    cyl10      = c2_cyl[ltc_pkg::CylW-1:0];

    res.chunk_count       = chunk;
    res.cylinder          = cyl10;
    res.head              = c2_head[ltc_pkg::HeadW-1:0];
    res.track_sector      = sec;
    res.ax_word           = {ltc_pkg::ReadFunc, 2'b00, chunk};
    res.cx_word           = {cyl10[7:0], cyl10[9:8], sec};
    res.dx_word           = {c2_head[ltc_pkg::HeadW-1:0], drive_q};
    res.next_rel_sector   = c2_side.rel + {{(QW-ltc_pkg::SptW){1'b0}}, chunk};
    res.request_done      = (c2_side.left ==
                             {{(ltc_pkg::LeftW-ltc_pkg::SptW){1'b0}}, chunk});
    res.cylinder_overflow = |c2_cyl[QW-1:ltc_pkg::CylW];
  end

  ltc_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (c2_valid),
    .data_i   (res),
    .advance_o(advance),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_data)
  );

  assign chunk_count_o       = out_data.chunk_count;
  assign cylinder_o          = out_data.cylinder;
  assign head_o              = out_data.head;
  assign track_sector_o      = out_data.track_sector;
  assign ax_word_o           = out_data.ax_word;
  assign cx_word_o           = out_data.cx_word;
  assign dx_word_o           = out_data.dx_word;
  assign next_rel_sector_o   = out_data.next_rel_sector;
  assign request_done_o      = out_data.request_done;
  assign cylinder_overflow_o = out_data.cylinder_overflow;

endmodule
